// File: rtl/lst_pkg.sv
`timescale 1ns / 1ps

package lst_pkg;

  localparam int VAL_W = 48;

  // request codes
  localparam logic [1:0] REQ_UPDATE = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_LOAD   = 2'd2;

  // merge codes, any other code merges as a sum
  localparam logic [1:0] MERGE_MIN = 2'd0;
  localparam logic [1:0] MERGE_MAX = 2'd1;

  // action codes
  localparam logic ACT_ASSIGN = 1'b0;

  // configuration register indexes
  localparam logic [1:0] CFG_MERGE  = 2'd0;
  localparam logic [1:0] CFG_ACTION = 2'd1;
  localparam logic [1:0] CFG_EMPTY  = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_CALC,
    ST_PUSH_WR,
    ST_CHILD_RD,
    ST_CHILD_WR,
    ST_PDONE,
    ST_BODY,
    ST_RET,
    ST_FIN
  } state_e;

  // what follows a finished tag push
  typedef enum logic [1:0] {
    PRET_VISIT,
    PRET_COVER,
    PRET_SIB
  } pret_e;

  typedef struct packed {
    logic [VAL_W-1:0] node;
    logic [VAL_W-1:0] tag;
    logic             valid;
  } ent_t;

  function automatic logic [VAL_W-1:0] merge_f(logic [1:0] mode, logic [VAL_W-1:0] a,
                                                logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] res;
    case (mode)
      MERGE_MIN: res = ($signed(a) <= $signed(b)) ? a : b;
      MERGE_MAX: res = ($signed(a) >= $signed(b)) ? a : b;
      default:   res = a + b;
    endcase
    return res;
  endfunction

endpackage

// File: rtl/lazy_segment_tree_range_ops_core.sv
`timescale 1ns / 1ps

// lazy segment tree over LEAVES 48-bit values: range assign/add, range min/max/sum, leaf load
// input channel: in_valid_i/in_ready_o carries req_type_i, left_i, right_i, value_i;
//   a beat is taken only while the sequencer is idle, one request at a time
// output channel: out_valid_o/out_ready_i carries result_o, one beat per query only;
//   a held result sits in the output register while the next request is taken,
//   and a later query waits at its end until the register is free
// config: cfg_we_i writes cfg_index_i (0 merge, 1 action, 2 empty value);
//   the user must write only while idle, which the block does not enforce; other indexes are ignored
// walk: every request walks the tree through one node/tag memory with one read and
//   one write port; a visited node reads its entry, applies a pending tag to the node
//   and at an inner node pushes it on to both children, then runs its body, and each
//   return step refreshes the parent; a covered node of an update takes another push;
//   an update or query visits up to about four nodes per level over log2(LEAVES)+1
//   levels, a leaf load two per level
// reset: the memory is cleared by a pass over all 2*2^ceil(log2(LEAVES)) entries, one
//   entry a cycle, during which in_ready_o stays low; config writes are taken meanwhile
// a stalled receiver only holds the result register; the tree walk is not affected

module lazy_segment_tree_range_ops_core
  import lst_pkg::*;
#(
  parameter int LEAVES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [9:0]         left_i,
  input  logic [10:0]        right_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [47:0] result_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [47:0]        cfg_data_i
);

  localparam int LOG       = $clog2(LEAVES);
  localparam int NODE_W    = LOG + 1;
  localparam int MEM_DEPTH = 1 << NODE_W;
  localparam int CW        = (NODE_W > 11) ? NODE_W : 11;
  localparam int DEPTHS    = LOG + 1;
  localparam int DEP_W     = $clog2(DEPTHS);

  // config registers
  logic [1:0]       merge_q;
  logic             action_q;
  logic [VAL_W-1:0] empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      merge_q  <= MERGE_MIN;
      action_q <= ACT_ASSIGN;
      empty_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MERGE:  merge_q  <= cfg_data_i[1:0];
        CFG_ACTION: action_q <= cfg_data_i[0];
        CFG_EMPTY:  empty_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // node/tag memory, one read and one write a cycle
  ent_t              mem [MEM_DEPTH];
  ent_t              rdata_q;
  logic              mem_we;
  logic [NODE_W-1:0] mem_waddr;
  logic [NODE_W-1:0] mem_raddr;
  ent_t              mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // per-level save slot for the left child (or load sibling) result
  logic [VAL_W-1:0] stk_node [DEPTHS];
  logic [VAL_W-1:0] stk_qv   [DEPTHS];
  logic             stk_we;
  logic [DEP_W-1:0] stk_idx;
  logic [VAL_W-1:0] stk_node_w;
  logic [VAL_W-1:0] stk_qv_w;

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_node[stk_idx] <= stk_node_w;
      stk_qv[stk_idx]   <= stk_qv_w;
    end
  end

  state_e            state_q, state_d;
  logic [NODE_W-1:0] clr_q, clr_d;
  logic [NODE_W-1:0] k_q, k_d;
  logic [CW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [DEP_W-1:0]  dep_q, dep_d;
  logic [1:0]        op_q, op_d;
  logic [NODE_W-1:0] p_addr_q, p_addr_d;
  logic [DEP_W-1:0]  p_shift_q, p_shift_d;
  logic              p_usex_q, p_usex_d;
  pret_e             p_ret_q, p_ret_d;
  logic              c_q, c_d;
  logic              out_valid_q, out_valid_d;

  // payload registers
  logic [CW-1:0]     l_q, l_d, r_q, r_d;
  logic [VAL_W-1:0]  x_q, x_d;
  logic [VAL_W-1:0]  amt_q, amt_d, nold_q, nold_d, tsrc_q, tsrc_d, pnode_q, pnode_d;
  logic              gor_q, gor_d;
  logic [VAL_W-1:0]  ret_v_q, ret_v_d, ret_r_q, ret_r_d;
  logic [VAL_W-1:0]  res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      k_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      dep_q       <= '0;
      op_q        <= REQ_UPDATE;
      p_addr_q    <= '0;
      p_shift_q   <= '0;
      p_usex_q    <= 1'b0;
      p_ret_q     <= PRET_VISIT;
      c_q         <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      k_q         <= k_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      dep_q       <= dep_d;
      op_q        <= op_d;
      p_addr_q    <= p_addr_d;
      p_shift_q   <= p_shift_d;
      p_usex_q    <= p_usex_d;
      p_ret_q     <= p_ret_d;
      c_q         <= c_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q     <= l_d;
    r_q     <= r_d;
    x_q     <= x_d;
    amt_q   <= amt_d;
    nold_q  <= nold_d;
    tsrc_q  <= tsrc_d;
    pnode_q <= pnode_d;
    gor_q   <= gor_d;
    ret_v_q <= ret_v_d;
    ret_r_q <= ret_r_d;
    res_q   <= res_d;
  end

  logic [CW-1:0]     size, mid, r_ext;
  logic [DEP_W-1:0]  pdep;
  logic [VAL_W-1:0]  comb_node, comb_q, tsrc_w, nnew;
  logic              veff, disjoint, covered;
  logic              go_visit;
  logic [NODE_W-1:0] nk;
  logic [CW-1:0]     nlo, nhi;
  logic [DEP_W-1:0]  ndep;

  assign size      = hi_q - lo_q;
  assign mid       = lo_q + (size >> 1);
  assign pdep      = dep_q - DEP_W'(1);
  assign comb_node = merge_f(merge_q, stk_node[pdep], ret_v_q);
  assign comb_q    = merge_f(merge_q, stk_qv[pdep], ret_r_q);
  assign veff      = p_usex_q | rdata_q.valid;
  assign tsrc_w    = p_usex_q ? x_q : rdata_q.tag;
  assign nnew      = (action_q == ACT_ASSIGN) ? amt_q : nold_q + amt_q;
  assign disjoint  = (hi_q <= l_q) || (r_q <= lo_q);
  assign covered   = (l_q <= lo_q) && (hi_q <= r_q);
  assign r_ext     = CW'(right_i);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    k_d         = k_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    dep_d       = dep_q;
    op_d        = op_q;
    p_addr_d    = p_addr_q;
    p_shift_d   = p_shift_q;
    p_usex_d    = p_usex_q;
    p_ret_d     = p_ret_q;
    c_d         = c_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    l_d         = l_q;
    r_d         = r_q;
    x_d         = x_q;
    amt_d       = amt_q;
    nold_d      = nold_q;
    tsrc_d      = tsrc_q;
    pnode_d     = pnode_q;
    gor_d       = gor_q;
    ret_v_d     = ret_v_q;
    ret_r_d     = ret_r_q;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = p_addr_q;
    mem_raddr   = p_addr_q;
    mem_wdata   = '{node: '0, tag: '0, valid: 1'b0};
    stk_we      = 1'b0;
    stk_idx     = dep_q;
    stk_node_w  = pnode_q;
    stk_qv_w    = pnode_q;
    go_visit    = 1'b0;
    nk          = k_q;
    nlo         = lo_q;
    nhi         = hi_q;
    ndep        = dep_q;
    in_ready_o  = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + NODE_W'(1);
        if (clr_q == NODE_W'(MEM_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d = req_type_i;
          l_d  = CW'(left_i);
          r_d  = (r_ext > CW'(LEAVES)) ? CW'(LEAVES) : r_ext;
          x_d  = {{(VAL_W - 32){value_i[31]}}, value_i};
          case (req_type_i)
            REQ_UPDATE: begin
              if (CW'(left_i) < r_d) begin
                go_visit = 1'b1;
              end
            end
            REQ_QUERY: begin
              if (CW'(left_i) < r_d) begin
                go_visit = 1'b1;
              end else begin
                ret_r_d = empty_q;
                state_d = ST_FIN;
              end
            end
            REQ_LOAD: begin
              if (CW'(left_i) < CW'(LEAVES)) begin
                go_visit = 1'b1;
              end
            end
            default: ;
          endcase
          nk   = NODE_W'(1);
          nlo  = '0;
          nhi  = CW'(1) << LOG;
          ndep = '0;
        end
      end

      ST_PUSH_RD: begin
        state_d = ST_PUSH_CALC;
      end

      ST_PUSH_CALC: begin
        nold_d = rdata_q.node;
        tsrc_d = tsrc_w;
        if (!veff) begin
          pnode_d = rdata_q.node;
          state_d = ST_PDONE;
        end else begin
          // node sizes are powers of two, so sum scaling is a shift
          if (merge_q == MERGE_MIN || merge_q == MERGE_MAX) begin
            amt_d = tsrc_w;
          end else begin
            amt_d = tsrc_w << p_shift_q;
          end
          state_d = ST_PUSH_WR;
        end
      end

      ST_PUSH_WR: begin
        mem_we    = 1'b1;
        mem_wdata = '{node: nnew, tag: '0, valid: 1'b0};
        pnode_d   = nnew;
        c_d       = 1'b0;
        state_d   = p_addr_q[LOG] ? ST_PDONE : ST_CHILD_RD;
      end

      ST_CHILD_RD: begin
        mem_raddr = {p_addr_q[LOG-1:0], c_q};
        state_d   = ST_CHILD_WR;
      end

      ST_CHILD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {p_addr_q[LOG-1:0], c_q};
        mem_wdata = '{node: rdata_q.node,
                      tag: (action_q == ACT_ASSIGN) ? tsrc_q : rdata_q.tag + tsrc_q,
                      valid: 1'b1};
        if (!c_q) begin
          c_d     = 1'b1;
          state_d = ST_CHILD_RD;
        end else begin
          state_d = ST_PDONE;
        end
      end

      ST_PDONE: begin
        case (p_ret_q)
          PRET_VISIT: state_d = ST_BODY;
          PRET_COVER: begin
            ret_v_d = pnode_q;
            ret_r_d = pnode_q;
            state_d = ST_RET;
          end
          default: begin
            // load: sibling settled, now walk down the path child
            stk_we     = 1'b1;
            stk_idx    = dep_q;
            stk_node_w = pnode_q;
            go_visit   = 1'b1;
            nk         = {k_q[LOG-1:0], gor_q};
            nlo        = gor_q ? mid : lo_q;
            nhi        = gor_q ? hi_q : mid;
            ndep       = dep_q + DEP_W'(1);
          end
        endcase
      end

      ST_BODY: begin
        if (op_q == REQ_LOAD) begin
          if (k_q[LOG]) begin
            mem_we    = 1'b1;
            mem_waddr = k_q;
            mem_wdata = '{node: x_q, tag: '0, valid: 1'b0};
            ret_v_d   = x_q;
            state_d   = ST_RET;
          end else begin
            gor_d     = (l_q >= mid);
            p_addr_d  = {k_q[LOG-1:0], ~(l_q >= mid)};
            p_shift_d = DEP_W'(LOG) - dep_q - DEP_W'(1);
            p_usex_d  = 1'b0;
            p_ret_d   = PRET_SIB;
            state_d   = ST_PUSH_RD;
          end
        end else if (disjoint) begin
          ret_v_d = pnode_q;
          ret_r_d = empty_q;
          state_d = ST_RET;
        end else if (covered) begin
          if (op_q == REQ_UPDATE) begin
            // apply the operand as a fresh tag on this node
            p_usex_d = 1'b1;
            p_ret_d  = PRET_COVER;
            state_d  = ST_PUSH_RD;
          end else begin
            ret_v_d = pnode_q;
            ret_r_d = pnode_q;
            state_d = ST_RET;
          end
        end else begin
          go_visit = 1'b1;
          nk       = {k_q[LOG-1:0], 1'b0};
          nhi      = mid;
          ndep     = dep_q + DEP_W'(1);
        end
      end

      ST_RET: begin
        if (dep_q == '0) begin
          state_d = (op_q == REQ_QUERY) ? ST_FIN : ST_IDLE;
        end else if (op_q != REQ_LOAD && !k_q[0]) begin
          // left child done: save it and visit the right sibling
          stk_we     = 1'b1;
          stk_idx    = pdep;
          stk_node_w = ret_v_q;
          stk_qv_w   = ret_r_q;
          go_visit   = 1'b1;
          nk         = k_q + NODE_W'(1);
          nlo        = hi_q;
          nhi        = hi_q + size;
        end else begin
          // both children known: refresh the parent and climb
          mem_we    = 1'b1;
          mem_waddr = k_q >> 1;
          mem_wdata = '{node: comb_node, tag: '0, valid: 1'b0};
          ret_v_d   = comb_node;
          ret_r_d   = comb_q;
          k_d       = k_q >> 1;
          dep_d     = pdep;
          if (k_q[0]) begin
            lo_d = lo_q - size;
          end else begin
            hi_d = hi_q + size;
          end
        end
      end

      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          res_d       = ret_r_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (go_visit) begin
      k_d       = nk;
      lo_d      = nlo;
      hi_d      = nhi;
      dep_d     = ndep;
      p_addr_d  = nk;
      p_shift_d = DEP_W'(LOG) - ndep;
      p_usex_d  = 1'b0;
      p_ret_d   = PRET_VISIT;
      state_d   = ST_PUSH_RD;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  // the tree is only touched by a request walk or the clearing pass
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_FIN) |-> !mem_we)
    else $error("memory written outside a walk");

  // the walk ends back at the root
  a_root_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RET && dep_q == '0) |-> (k_q == NODE_W'(1) && lo_q == '0))
    else $error("walk returned to level zero off the root");

  // a visited node always spans at least one leaf
  a_span_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BODY) |-> (hi_q > lo_q))
    else $error("visited node with empty span");

  // leaves never hand tags down
  a_child_internal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHILD_RD || state_q == ST_CHILD_WR) |-> !p_addr_q[LOG])
    else $error("tag pushed below a leaf");

  // a query walk ends in a result beat
  a_fin_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RET && dep_q == '0 && op_q == REQ_QUERY) |=> (state_q == ST_FIN))
    else $error("query finished without a result");

endmodule
